>>> rtl/chrt_pkg.sv
// Package for the consistent hash ring table: sizes, command and status codes,
// word and entry types, and the control and link structs shared by the cells.
// No dependencies.
`timescale 1ns / 1ps

package chrt_pkg;

    // Ring and field sizes.
    localparam int RING_DEPTH  = 256;
    localparam int MAX_SERVERS = 64;
    localparam int POINT_W     = 32;
    localparam int SID_W       = 6;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int IDX_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Grouping of the registered result tree.
    localparam int GRP  = 16;
    localparam int NGRP = (RING_DEPTH + GRP - 1) / GRP;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Input word.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [POINT_W-1:0] hash_point;
        logic [SID_W-1:0]   server_id;
        logic               is_physical;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SID_W-1:0]       found_server;
        logic [POINT_W-1:0]     found_point;
        logic                   found_physical;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_out_word;

    // One ring entry.
    typedef struct packed {
        logic [POINT_W-1:0] point;
        logic [SID_W-1:0]   server;
        logic               physical;
    } t_entry;

    // Operation broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic look;
        logic mark;
        logic swap;
        logic phase;
        logic settle;
    } t_cell_ctl;

    // What a cell shows its neighbors.
    typedef struct packed {
        t_entry ent;
        logic   valid;
        logic   hole;
        logic   gt;
        logic   ge;
    } t_link;

endpackage

>>> rtl/consistent_hash_ring_table_unit.sv
// Top level of the consistent hash ring table: sequencer, row of ring cells,
// result tree and output register. Depends on chrt_pkg, chrt_cell and chrt_tree.
`timescale 1ns / 1ps

// The ring is a row of RING_DEPTH cells, one entry each, kept sorted by point.
// One command word is worked at a time; o_in_stall is low only while the
// sequencer is idle, and the result waits in an output register so the next
// word can be taken while the previous result is still stalled. A lookup
// first has every cell compare its point against the key and register a hit,
// then passes the hits through the registered OR tree, then loads the
// output register. An insert loads the output register once all cells have
// compared and shifted together in the insert state. In a remove, the
// deleted entries drift to the end of the row through RING_DEPTH odd-even
// exchange passes between neighbor cells, then the count is trimmed one
// entry a cycle. The next word is taken in the cycle after the result is
// registered. No clearing pass is needed after reset.
module consistent_hash_ring_table_unit import chrt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_LOOK1  = 10'b00_0000_0010,
        S_LOOK2  = 10'b00_0000_0100,
        S_LOOK3  = 10'b00_0000_1000,
        S_INSERT = 10'b00_0001_0000,
        S_MARK   = 10'b00_0010_0000,
        S_SWAP   = 10'b00_0100_0000,
        S_SETTLE = 10'b00_1000_0000,
        S_TRIM   = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state              r_state, n_state;
    t_in_word            r_req, n_req;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [IDX_W-1:0]    r_step, n_step;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out, n_out;

    t_cell_ctl               w_ctl;
    t_entry                  w_key;
    t_link  [RING_DEPTH-1:0] w_link;
    logic   [RING_DEPTH-1:0] w_hit;
    logic   [RING_DEPTH-1:0] w_hole;
    t_entry [RING_DEPTH-1:0] w_ents;
    t_link                   w_edge;
    logic                    w_tree_any;
    t_entry                  w_tree_ent;
    logic                    w_accept;
    logic                    w_sid_ok;
    logic                    w_ins_ok;
    logic                    w_out_free;
    logic [CNT_W-1:0]        w_cnt_m1;
    t_entry                  w_sel;
    t_out_word               w_out;

    assign w_key = '{point: r_req.hash_point, server: r_req.server_id,
                     physical: r_req.is_physical};

    // Outside neighbor of the end cells: empty, a hole, never selected.
    assign w_edge = '{ent: '0, valid: 1'b0, hole: 1'b1, gt: 1'b1, ge: 1'b0};

    // Row of ring cells.
    for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
        chrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_key   (w_key),
            .i_first (1'(i == 0)),
            .i_last  (1'(i == RING_DEPTH - 1)),
            .i_odd   (1'(i % 2)),
            .i_left  ((i == 0) ? w_edge : w_link[(i == 0) ? 0 : i - 1]),
            .i_right ((i == RING_DEPTH - 1) ? w_edge
                                            : w_link[(i == RING_DEPTH - 1) ? i : i + 1]),
            .o_link  (w_link[i]),
            .o_hit   (w_hit[i])
        );
        assign w_hole[i] = w_link[i].hole;
        assign w_ents[i] = w_link[i].ent;
    end

    // Result selection tree.
    chrt_tree u_tree (
        .i_clk  (i_clk),
        .i_hit  (w_hit),
        .i_ents (w_ents),
        .o_any  (w_tree_any),
        .o_ent  (w_tree_ent)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_sid_ok   = int'(r_req.server_id) < MAX_SERVERS;
    assign w_ins_ok   = w_sid_ok && (r_count < CNT_W'(RING_DEPTH));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cnt_m1   = r_count - CNT_W'(1);

    // Cell operation for the current state.
    always_comb begin
        w_ctl        = '0;
        w_ctl.ins    = (r_state == S_INSERT) && w_ins_ok;
        w_ctl.look   = (r_state == S_LOOK1);
        w_ctl.mark   = (r_state == S_MARK);
        w_ctl.swap   = (r_state == S_SWAP);
        w_ctl.phase  = r_step[0];
        w_ctl.settle = (r_state == S_SETTLE);
    end

    // Result word for the finished command.
    always_comb begin
        w_sel = w_tree_any ? w_tree_ent : w_ents[0];
        w_out = '0;
        w_out.status      = r_status;
        w_out.entry_count = COUNT_OUT_W'(r_count);
        if (r_req.command == CMD_LOOKUP) begin
            if (r_count == '0) begin
                w_out.status = STAT_EMPTY;
            end else begin
                w_out.found_server   = w_sel.server;
                w_out.found_point    = w_sel.point;
                w_out.found_physical = w_sel.physical;
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_step      = r_step;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req    = i_in_word;
                    n_status = STAT_OK;
                    case (i_in_word.command)
                        CMD_LOOKUP: n_state = S_LOOK1;
                        CMD_INSERT: n_state = S_INSERT;
                        CMD_REMOVE: n_state = S_MARK;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_LOOK1: n_state = S_LOOK2;
            S_LOOK2: n_state = S_LOOK3;
            S_LOOK3: n_state = S_DONE;
            S_INSERT: begin
                if (w_ins_ok) begin
                    n_count = r_count + CNT_W'(1);
                end else if (w_sid_ok) begin
                    n_status = STAT_FULL;
                end
                n_state = S_DONE;
            end
            S_MARK: begin
                n_step  = '0;
                n_state = S_SWAP;
            end
            S_SWAP: begin
                n_step = r_step + IDX_W'(1);
                if (r_step == IDX_W'(RING_DEPTH - 1)) begin
                    n_state = S_SETTLE;
                end
            end
            S_SETTLE: n_state = S_TRIM;
            S_TRIM: begin
                // Deleted entries now sit at the end of the row.
                if ((r_count != '0) && w_hole[w_cnt_m1[IDX_W-1:0]]) begin
                    n_count = w_cnt_m1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = w_out;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RING_DEPTH))
        else $error("ring count above ring depth");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("second word taken while a command is in progress");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word appeared outside the finishing state");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_INSERT) && w_ins_ok) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not advance the ring count");

    a_trim_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM) |=> (r_count <= $past(r_count)))
        else $error("ring count grew during a remove");
`endif

endmodule

>>> rtl/chrt_cell.sv
// One cell of the ring: holds a single entry and trades data with its neighbors.
// Depends on chrt_pkg.
`timescale 1ns / 1ps

module chrt_cell import chrt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_key,
    input  logic      i_first,
    input  logic      i_last,
    input  logic      i_odd,
    input  t_link     i_left,
    input  t_link     i_right,
    output t_link     o_link,
    output logic      o_hit
);

    t_entry r_ent, n_ent;
    logic   r_valid, n_valid;
    logic   r_hole, n_hole;
    logic   r_hit, n_hit;
    logic   w_gt, w_ge;
    logic   w_left_member, w_right_member;

    // An insert goes in front of the first cell that is empty or holds a larger point.
    assign w_gt = !r_valid || (r_ent.point > i_key.point);
    // A lookup selects the first valid cell whose point is at or above the key.
    assign w_ge = r_valid && (r_ent.point >= i_key.point);

    // Pairing for the odd-even exchange passes.
    assign w_left_member  = (i_odd == i_ctl.phase) && !i_last;
    assign w_right_member = (i_odd != i_ctl.phase) && !i_first;

    // Next state of the cell.
    always_comb begin
        n_ent   = r_ent;
        n_valid = r_valid;
        n_hole  = r_hole;
        n_hit   = r_hit;
        if (i_ctl.ins && w_gt) begin
            if (i_first || !i_left.gt) begin
                n_ent   = i_key;
                n_valid = 1'b1;
            end else begin
                n_ent   = i_left.ent;
                n_valid = i_left.valid;
            end
        end
        if (i_ctl.look) begin
            n_hit = w_ge && (i_first || !i_left.ge);
        end
        if (i_ctl.mark) begin
            n_hole = !r_valid || (r_ent.server == i_key.server);
        end
        if (i_ctl.swap) begin
            // A hole trades places with a kept entry on its right.
            if (w_left_member && r_hole && !i_right.hole) begin
                n_ent  = i_right.ent;
                n_hole = 1'b0;
            end
            if (w_right_member && i_left.hole && !r_hole) begin
                n_ent  = i_left.ent;
                n_hole = 1'b1;
            end
        end
        if (i_ctl.settle) begin
            n_valid = !r_hole;
        end
    end

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hole  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_hole  <= n_hole;
            r_hit   <= n_hit;
        end
    end

    // Entry payload.
    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_link = '{ent: r_ent, valid: r_valid, hole: r_hole, gt: w_gt, ge: w_ge};
    assign o_hit  = r_hit;

endmodule

>>> rtl/chrt_tree.sv
// Registered two-level OR tree that picks the entry of the single hit cell.
// Depends on chrt_pkg.
`timescale 1ns / 1ps

module chrt_tree import chrt_pkg::*; (
    input  logic                    i_clk,
    input  logic [RING_DEPTH-1:0]   i_hit,
    input  t_entry [RING_DEPTH-1:0] i_ents,
    output logic                    o_any,
    output t_entry                  o_ent
);

    logic   [NGRP-1:0] r_grp_hit, n_grp_hit;
    t_entry [NGRP-1:0] r_grp_ent, n_grp_ent;
    logic              r_any, n_any;
    t_entry            r_ent, n_ent;

    // First level: OR within each group of cells.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp_hit[g] = 1'b0;
            n_grp_ent[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < RING_DEPTH) begin
                    if (i_hit[g * GRP + k]) begin
                        n_grp_hit[g] = 1'b1;
                        n_grp_ent[g] = n_grp_ent[g] | i_ents[g * GRP + k];
                    end
                end
            end
        end
    end

    // Second level: OR across the groups.
    always_comb begin
        n_any = 1'b0;
        n_ent = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_grp_hit[g]) begin
                n_any = 1'b1;
                n_ent = n_ent | r_grp_ent[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_hit <= n_grp_hit;
        r_grp_ent <= n_grp_ent;
        r_any     <= n_any;
        r_ent     <= n_ent;
    end

    assign o_any = r_any;
    assign o_ent = r_ent;

endmodule
